/* rtl/mcwdt_pkg.sv */
// Package for the multi-client watchdog table: sizes, field widths, codes
// and the countdown load function. No dependencies.
// Used by multi_client_watchdog_table_core.
package mcwdt_pkg;

  // Table geometry and timing
  localparam int TABLE_DEPTH      = 16;
  localparam int TICKS_PER_SECOND = 100;
  localparam int MAX_RESULTS      = 16;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  // Field widths
  localparam int CLIENT_W  = 22;
  localparam int REMAIN_W  = 18;
  localparam int TIMEOUT_W = 8;
  localparam int SIGNAL_W  = 7;
  localparam int TPS_W     = 10;
  localparam int PROD_W    = TIMEOUT_W + TPS_W;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNAL  = 8'd1;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 8'd5;
  localparam logic [SIGNAL_W-1:0]  SIGNAL_RST  = 7'd15;   // SIGTERM

  // Command codes
  localparam logic [1:0] MODE_REGISTER = 2'd0;
  localparam logic [1:0] MODE_KICK     = 2'd1;
  localparam logic [1:0] MODE_RELEASE  = 2'd2;
  localparam logic [1:0] MODE_TICK     = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_EXPIRY = 2'd1;
  localparam logic [1:0] KIND_QUIET  = 2'd2;

  // Command status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_KNOWN     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic [REMAIN_W-1:0] REMAIN_MAX = '1;

  // Countdown load: seconds times ticks per second, saturated to the counter
  function automatic logic [REMAIN_W-1:0] load_value(input logic [TIMEOUT_W-1:0] secs);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(secs) * PROD_W'(TICKS_PER_SECOND);
    if (prod > PROD_W'(REMAIN_MAX)) begin
      return REMAIN_MAX;
    end
    return REMAIN_W'(prod);
  endfunction

endpackage

/* rtl/multi_client_watchdog_table_core.sv */
// Multi-client watchdog table: top level with slot store and sequencer.
// Depends on mcwdt_pkg.
//
// One command is taken at a time and the sequencer then walks the slot table,
// one slot per cycle through a single compare/decrement datapath, though a
// tick walk can stall. Register, kick and release search all TABLE_DEPTH
// slots and then apply the change once the status result can be handed to
// the output register; only then can the next command be taken.
// A tick walks all TABLE_DEPTH slots the same way and emits one
// expiry per expired slot in ascending slot order; the walk pauses while an
// expiry cannot be handed to the output register. The slot table is empty
// after reset and needs no clearing pass. Configuration writes are always
// taken and must only be issued while no command is in progress.
module multi_client_watchdog_table_core (
  input  logic        clk,
  input  logic        rst,
  // command stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,    // [21:0] client_id, [23:22] zero
  input  logic [1:0]  s_tuser,    // [1:0] mode
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // [1:0] status, [23:2] expired_client,
                                  // [30:24] signal_out, [31] zero
  output logic [1:0]  m_tuser,    // [1:0] kind
  output logic        m_tlast,    // last result of the command
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_CMD  = 3'd2;
  localparam logic [2:0] S_TICK = 3'd3;
  localparam logic [2:0] S_TEND = 3'd4;

  localparam logic [mcwdt_pkg::IDX_W-1:0] IDX_LAST =
    mcwdt_pkg::IDX_W'(mcwdt_pkg::TABLE_DEPTH - 1);

  // Configuration
  logic [mcwdt_pkg::TIMEOUT_W-1:0] timeout_seconds;
  logic [mcwdt_pkg::SIGNAL_W-1:0]  signal_number;

  // Sequencer
  logic [2:0]                      state;
  logic [mcwdt_pkg::IDX_W-1:0]     idx;
  logic [1:0]                      cmd_mode;
  logic [mcwdt_pkg::CLIENT_W-1:0]  cmd_client;
  logic                            hit;
  logic [mcwdt_pkg::IDX_W-1:0]     hit_idx;
  logic                            free_ok;
  logic [mcwdt_pkg::IDX_W-1:0]     free_idx;
  logic [mcwdt_pkg::CNT_W-1:0]     exp_cnt;
  logic                            pend_valid;
  logic [mcwdt_pkg::CLIENT_W-1:0]  pend_client;

  // Slot table
  logic [mcwdt_pkg::TABLE_DEPTH-1:0] slot_valid;
  logic [mcwdt_pkg::TABLE_DEPTH-1:0] slot_armed;
  logic [mcwdt_pkg::CLIENT_W-1:0]    slot_client    [mcwdt_pkg::TABLE_DEPTH];
  logic [mcwdt_pkg::REMAIN_W-1:0]    slot_remaining [mcwdt_pkg::TABLE_DEPTH];

  // Shared datapath
  logic [mcwdt_pkg::CLIENT_W-1:0] rd_client;
  logic [mcwdt_pkg::REMAIN_W-1:0] rd_remain;
  logic [mcwdt_pkg::REMAIN_W-1:0] load;
  logic                           cur_armed;
  logic                           count_on;
  logic                           need_emit;
  logic                           out_free;
  logic                           tick_go;
  logic [1:0]                     cmd_status;

  // Table write port
  logic                           we_client;
  logic                           we_remain;
  logic [mcwdt_pkg::IDX_W-1:0]    wr_idx;
  logic [mcwdt_pkg::REMAIN_W-1:0] wr_remain;

  // Output register load
  logic                           push;
  logic [1:0]                     push_kind;
  logic [1:0]                     push_status;
  logic [mcwdt_pkg::CLIENT_W-1:0] push_client;
  logic [mcwdt_pkg::SIGNAL_W-1:0] push_sig;
  logic                           push_last;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign rd_client = slot_client[idx];
  assign rd_remain = slot_remaining[idx];
  assign load      = mcwdt_pkg::load_value(timeout_seconds);
  assign cur_armed = slot_armed[idx];
  assign count_on  = rd_remain > mcwdt_pkg::REMAIN_W'(1);
  assign need_emit = cur_armed && !count_on &&
                     (exp_cnt < mcwdt_pkg::CNT_W'(mcwdt_pkg::MAX_RESULTS));
  assign out_free  = !m_tvalid || m_tready;
  // stall the walk while a held expiry cannot be handed on
  assign tick_go   = !(need_emit && pend_valid && !out_free);

  // Decide the command status from the search results
  always_comb begin
    unique case (cmd_mode)
      mcwdt_pkg::MODE_REGISTER: begin
        if (hit) begin
          cmd_status = mcwdt_pkg::ST_KNOWN;
        end else if (free_ok) begin
          cmd_status = mcwdt_pkg::ST_DONE;
        end else begin
          cmd_status = mcwdt_pkg::ST_FULL;
        end
      end
      mcwdt_pkg::MODE_KICK, mcwdt_pkg::MODE_RELEASE: begin
        cmd_status = hit ? mcwdt_pkg::ST_DONE : mcwdt_pkg::ST_NOT_FOUND;
      end
      default: cmd_status = mcwdt_pkg::ST_DONE;
    endcase
  end

  // Steer the single table write port and the output register load
  always_comb begin
    we_client   = 1'b0;
    we_remain   = 1'b0;
    wr_idx      = idx;
    wr_remain   = load;
    push        = 1'b0;
    push_kind   = mcwdt_pkg::KIND_STATUS;
    push_status = mcwdt_pkg::ST_DONE;
    push_client = '0;
    push_sig    = '0;
    push_last   = 1'b1;
    unique case (state)
      S_TICK: begin
        if (tick_go && cur_armed) begin
          we_remain = 1'b1;
          wr_remain = count_on ? rd_remain - mcwdt_pkg::REMAIN_W'(1) : '0;
        end
        if (need_emit && pend_valid && out_free) begin
          push        = 1'b1;
          push_kind   = mcwdt_pkg::KIND_EXPIRY;
          push_client = pend_client;
          push_sig    = signal_number;
          push_last   = 1'b0;
        end
      end
      S_CMD: begin
        if (out_free) begin
          push        = 1'b1;
          push_status = cmd_status;
          if (cmd_mode == mcwdt_pkg::MODE_REGISTER && !hit && free_ok) begin
            we_client = 1'b1;
            we_remain = 1'b1;
            wr_idx    = free_idx;
          end else if (cmd_mode == mcwdt_pkg::MODE_KICK && hit) begin
            we_remain = 1'b1;
            wr_idx    = hit_idx;
          end
        end
      end
      S_TEND: begin
        if (out_free) begin
          push = 1'b1;
          if (pend_valid) begin
            push_kind   = mcwdt_pkg::KIND_EXPIRY;
            push_client = pend_client;
            push_sig    = signal_number;
          end else begin
            push_kind = mcwdt_pkg::KIND_QUIET;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Slot payload store and result payload
  always_ff @(posedge clk) begin
    if (we_client) begin
      slot_client[wr_idx] <= cmd_client;
    end
    if (we_remain) begin
      slot_remaining[wr_idx] <= wr_remain;
    end
    if (push) begin
      m_tdata <= {1'b0, push_sig, push_client, push_status};
      m_tuser <= push_kind;
      m_tlast <= push_last;
    end
  end

  // Control state, configuration and slot flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      idx             <= '0;
      hit             <= 1'b0;
      free_ok         <= 1'b0;
      exp_cnt         <= '0;
      pend_valid      <= 1'b0;
      m_tvalid        <= 1'b0;
      slot_valid      <= '0;
      slot_armed      <= '0;
      timeout_seconds <= mcwdt_pkg::TIMEOUT_RST;
      signal_number   <= mcwdt_pkg::SIGNAL_RST;
    end else begin
      // take configuration transfers
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == mcwdt_pkg::REG_TIMEOUT) begin
          timeout_seconds <= cfg_data;
        end else if (cfg_index == mcwdt_pkg::REG_SIGNAL) begin
          signal_number <= cfg_data[mcwdt_pkg::SIGNAL_W-1:0];
        end
      end

      // hold or drop the output register
      if (push) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd_mode   <= s_tuser;
            cmd_client <= s_tdata[mcwdt_pkg::CLIENT_W-1:0];
            idx        <= '0;
            hit        <= 1'b0;
            free_ok    <= 1'b0;
            exp_cnt    <= '0;
            pend_valid <= 1'b0;
            state      <= (s_tuser == mcwdt_pkg::MODE_TICK) ? S_TICK : S_SCAN;
          end
        end

        // search for the client and the lowest free slot
        S_SCAN: begin
          if (slot_valid[idx] && rd_client == cmd_client && !hit) begin
            hit     <= 1'b1;
            hit_idx <= idx;
          end
          if (!slot_valid[idx] && !free_ok) begin
            free_ok  <= 1'b1;
            free_idx <= idx;
          end
          if (idx == IDX_LAST) begin
            state <= S_CMD;
          end else begin
            idx <= idx + 1'b1;
          end
        end

        // apply the command once the status can be handed on
        S_CMD: begin
          if (out_free) begin
            if (cmd_mode == mcwdt_pkg::MODE_REGISTER && !hit && free_ok) begin
              slot_valid[free_idx] <= 1'b1;
              slot_armed[free_idx] <= 1'b1;
            end else if (cmd_mode == mcwdt_pkg::MODE_KICK && hit) begin
              slot_armed[hit_idx] <= 1'b1;
            end else if (cmd_mode == mcwdt_pkg::MODE_RELEASE && hit) begin
              slot_valid[hit_idx] <= 1'b0;
              slot_armed[hit_idx] <= 1'b0;
            end
            state <= S_IDLE;
          end
        end

        // count down each armed slot, hold the newest expiry back
        S_TICK: begin
          if (tick_go) begin
            if (need_emit) begin
              slot_armed[idx] <= 1'b0;
              exp_cnt         <= exp_cnt + 1'b1;
              pend_valid      <= 1'b1;
              pend_client     <= rd_client;
            end
            if (idx == IDX_LAST) begin
              state <= S_TEND;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end

        // send the final result of the tick
        S_TEND: begin
          if (out_free) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
